FILE: src/pat_pkg.sv
// ---------------------------------------------------------------------------
// pat_pkg
// Shared types and constants for the point affine transform block.
// ---------------------------------------------------------------------------
package pat_pkg;

  localparam int IMAGE_WIDTH  = 256;
  localparam int IMAGE_HEIGHT = 256;

  // Product and sum widths: 17b operand x 17b coefficient, then one add.
  localparam int PW = 34;
  localparam int SW = PW + 1;

  typedef enum logic [2:0] {
    OP_MIRROR_V  = 3'd0,
    OP_MIRROR_H  = 3'd1,
    OP_ROT_ORIG  = 3'd2,
    OP_ROT_CTR   = 3'd3,
    OP_SHEAR_Y   = 3'd4,
    OP_SHEAR_XY  = 3'd5
  } pat_op_t;

  localparam logic [1:0] REG_COS = 2'd0;
  localparam logic [1:0] REG_SIN = 2'd1;
  localparam logic [1:0] REG_TAN = 2'd2;

  localparam logic signed [15:0] COS_RESET = 16'sd16384;
  localparam logic signed [15:0] SIN_RESET = 16'sd0;
  localparam logic signed [15:0] TAN_RESET = 16'sd2365;

  // Coefficient registers handed to the datapath.
  typedef struct packed {
    logic signed [15:0] cos_q;
    logic signed [15:0] sin_q;
    logic signed [15:0] tan_q;
  } pat_coef_t;

endpackage

FILE: src/point_affine_transform.sv
// ---------------------------------------------------------------------------
// point_affine_transform
// Mirror, rotate and shear of one 16-bit integer point per beat.
// ---------------------------------------------------------------------------
// Takes one point per clock and returns the transformed point; throughput
// is one beat per cycle while the output is not stalled. Each of the five
// stages (select, multiply, sum, truncate, center add and saturate) holds
// its beat independently so a stalled output only backs up the stages
// that are full. Cos and sin are Q2.14, tan is Q4.12; fixed-point results
// truncate toward zero and saturate to 16 bits with the overflow flag set.
// Coefficients are written through the cfg port (index 0 cos, 1 sin, 2 tan,
// others ignored), which is always ready; write them only while idle.
// ---------------------------------------------------------------------------
module point_affine_transform
  import pat_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic signed [15:0] x_in,
  input  logic signed [15:0] y_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] x_out,
  output logic signed [15:0] y_out,
  output logic               overflow
);

  pat_coef_t coef;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.cos_q <= COS_RESET;
      coef.sin_q <= SIN_RESET;
      coef.tan_q <= TAN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COS: coef.cos_q <= cfg_data;
        REG_SIN: coef.sin_q <= cfg_data;
        REG_TAN: coef.tan_q <= cfg_data;
        default: coef.tan_q <= coef.tan_q;
      endcase
    end
  end

  pat_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .x_in      (x_in),
    .y_in      (y_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .x_out     (x_out),
    .y_out     (y_out),
    .overflow  (overflow)
  );

endmodule

FILE: src/pat_pipe.sv
// ---------------------------------------------------------------------------
// pat_pipe
// Five-stage transform datapath: operand select, multiply, sum, truncate,
// center add and saturate. Per-stage valid bits with local ready.
// ---------------------------------------------------------------------------
module pat_pipe
  import pat_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  pat_coef_t          coef,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic signed [15:0] x_in,
  input  logic signed [15:0] y_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] x_out,
  output logic signed [15:0] y_out,
  output logic               overflow
);

  localparam logic signed [16:0] CX17   = 17'(IMAGE_WIDTH / 2);
  localparam logic signed [16:0] CY17   = 17'(IMAGE_HEIGHT / 2);
  localparam logic signed [17:0] WM1    = 18'(IMAGE_WIDTH - 1);
  localparam logic signed [17:0] HM1    = 18'(IMAGE_HEIGHT - 1);
  localparam logic signed [SW-1:0] CXS  = SW'(IMAGE_WIDTH / 2);
  localparam logic signed [SW-1:0] CYS  = SW'(IMAGE_HEIGHT / 2);
  localparam logic signed [SW-1:0] M14  = SW'((1 << 14) - 1);
  localparam logic signed [SW-1:0] M12  = SW'((1 << 12) - 1);
  localparam logic signed [SW-1:0] SMAX = SW'(32767);
  localparam logic signed [SW-1:0] SMIN = -SW'(32768);
  localparam logic signed [16:0] ONE12  = 17'sd4096;

  // ---------------- stage 1: operand and coefficient select ----------------
  logic signed [16:0] a_next, b_next, c0_next, c1_next, c2_next, c3_next;
  logic signed [17:0] dirx_next, diry_next;
  logic mulx_next, muly_next, f14_next, cen_next;
  logic signed [16:0] xe, ye, dx, dy, cos_e, sin_e, tan_e;

  always_comb begin
    xe    = {x_in[15], x_in};
    ye    = {y_in[15], y_in};
    dx    = xe - CX17;
    dy    = ye - CY17;
    cos_e = {coef.cos_q[15], coef.cos_q};
    sin_e = {coef.sin_q[15], coef.sin_q};
    tan_e = {coef.tan_q[15], coef.tan_q};
    a_next    = xe;
    b_next    = ye;
    c0_next   = cos_e;
    c1_next   = sin_e;
    c2_next   = sin_e;
    c3_next   = cos_e;
    dirx_next = {xe[16], xe};
    diry_next = {ye[16], ye};
    mulx_next = 1'b0;
    muly_next = 1'b0;
    f14_next  = 1'b1;
    cen_next  = 1'b0;
    // x = a*c0 - b*c1, y = a*c2 + b*c3
    case (pat_op_t'(opcode))
      OP_MIRROR_V: begin
        diry_next = HM1 - {ye[16], ye};
      end
      OP_MIRROR_H: begin
        dirx_next = WM1 - {xe[16], xe};
      end
      OP_ROT_ORIG: begin
        mulx_next = 1'b1;
        muly_next = 1'b1;
      end
      OP_ROT_CTR: begin
        a_next    = dx;
        b_next    = dy;
        mulx_next = 1'b1;
        muly_next = 1'b1;
        cen_next  = 1'b1;
      end
      OP_SHEAR_Y: begin
        a_next    = dx;
        b_next    = dy;
        c2_next   = tan_e;
        c3_next   = ONE12;
        muly_next = 1'b1;
        f14_next  = 1'b0;
        cen_next  = 1'b1;
      end
      OP_SHEAR_XY: begin
        a_next    = dx;
        b_next    = dy;
        c0_next   = ONE12;
        c1_next   = -tan_e;
        c2_next   = tan_e;
        c3_next   = ONE12;
        mulx_next = 1'b1;
        muly_next = 1'b1;
        f14_next  = 1'b0;
        cen_next  = 1'b1;
      end
      default: begin
        // unused codes pass the point through
        mulx_next = 1'b0;
      end
    endcase
  end

  // ---------------- stage registers ----------------
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !out_valid || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  logic signed [16:0] a1, b1, c0_1, c1_1, c2_1, c3_1;
  logic signed [17:0] dirx1, diry1, dirx2, diry2, dirx3, diry3, dirx4, diry4;
  logic mulx1, muly1, f14_1, cen1;
  logic mulx2, muly2, f14_2, cen2;
  logic mulx3, muly3, f14_3, cen3;
  logic mulx4, muly4, cen4;
  logic signed [PW-1:0] m0, m1, m2, m3;
  logic signed [SW-1:0] xs, ys, xt, yt;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) out_valid <= v4;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      a1    <= a_next;
      b1    <= b_next;
      c0_1  <= c0_next;
      c1_1  <= c1_next;
      c2_1  <= c2_next;
      c3_1  <= c3_next;
      dirx1 <= dirx_next;
      diry1 <= diry_next;
      mulx1 <= mulx_next;
      muly1 <= muly_next;
      f14_1 <= f14_next;
      cen1  <= cen_next;
    end
  end

  // stage 2: four products
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      m0    <= a1 * c0_1;
      m1    <= b1 * c1_1;
      m2    <= a1 * c2_1;
      m3    <= b1 * c3_1;
      dirx2 <= dirx1;
      diry2 <= diry1;
      mulx2 <= mulx1;
      muly2 <= muly1;
      f14_2 <= f14_1;
      cen2  <= cen1;
    end
  end

  // stage 3: sums
  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      xs    <= SW'(m0) - SW'(m1);
      ys    <= SW'(m2) + SW'(m3);
      dirx3 <= dirx2;
      diry3 <= diry2;
      mulx3 <= mulx2;
      muly3 <= muly2;
      f14_3 <= f14_2;
      cen3  <= cen2;
    end
  end

  // stage 4: shift right, rounding toward zero (bias negatives first)
  logic signed [SW-1:0] mask3, xb, yb;

  always_comb begin
    mask3 = f14_3 ? M14 : M12;
    xb    = xs + (xs[SW-1] ? mask3 : '0);
    yb    = ys + (ys[SW-1] ? mask3 : '0);
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      xt    <= f14_3 ? (xb >>> 14) : (xb >>> 12);
      yt    <= f14_3 ? (yb >>> 14) : (yb >>> 12);
      dirx4 <= dirx3;
      diry4 <= diry3;
      mulx4 <= mulx3;
      muly4 <= muly3;
      cen4  <= cen3;
    end
  end

  // stage 5: center add, select, saturate into the output register
  logic signed [SW-1:0] xr, yr;
  logic signed [15:0]   xsat, ysat;
  logic                 xovf, yovf;

  always_comb begin
    xr = mulx4 ? (xt + (cen4 ? CXS : '0)) : SW'(dirx4);
    yr = muly4 ? (yt + (cen4 ? CYS : '0)) : SW'(diry4);
    xovf = 1'b1;
    yovf = 1'b1;
    if (xr > SMAX)      xsat = 16'sh7fff;
    else if (xr < SMIN) xsat = -16'sh8000;
    else begin
      xsat = xr[15:0];
      xovf = 1'b0;
    end
    if (yr > SMAX)      ysat = 16'sh7fff;
    else if (yr < SMIN) ysat = -16'sh8000;
    else begin
      ysat = yr[15:0];
      yovf = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4) begin
      x_out    <= xsat;
      y_out    <= ysat;
      overflow <= xovf || yovf;
    end
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for point_affine_transform. The bench predicts each
// transformed point from its own copy of the coefficients and checks every
// output beat in order. It drives directed corner points, random points under
// several coefficient settings, a long output stall and a gap-free stream.
// ---------------------------------------------------------------------------
module tb
  import pat_pkg::*;
;

  localparam logic [2:0] OP_UNUSED_6  = 3'd6;
  localparam logic [2:0] OP_UNUSED_7  = 3'd7;
  localparam logic [1:0] REG_NONE     = 2'd3;
  localparam int         DRAIN_CYCLES = 16;
  localparam int         HOLD_CYCLES  = 80;
  localparam int         ITEMS_PER_SETTING = 240;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               ovf;
  } point_result_t;

  typedef struct {
    logic signed [15:0] cos_q;
    logic signed [15:0] sin_q;
    logic signed [15:0] tan_q;
  } coef_set_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = REG_COS;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         opcode = OP_MIRROR_V;
  logic signed [15:0] x_in = '0;
  logic signed [15:0] y_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] x_out;
  logic signed [15:0] y_out;
  logic               overflow;

  // coefficient copies used for prediction
  logic signed [15:0] cos_coef = COS_RESET;
  logic signed [15:0] sin_coef = SIN_RESET;
  logic signed [15:0] tan_coef = TAN_RESET;

  point_result_t expected_points[$];
  int  errors          = 0;
  int  points_sent     = 0;
  int  points_checked  = 0;
  int  coef_writes     = 0;
  int  hold_req        = 0;
  bit  quiet           = 1'b0;

  point_affine_transform DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .x_in      (x_in),
    .y_in      (y_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .x_out     (x_out),
    .y_out     (y_out),
    .overflow  (overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic signed [15:0] clamp16(input longint v, inout logic ovf);
    if (v > 32767) begin
      ovf = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      ovf = 1'b1;
      return 16'sh8000;
    end
    return 16'(v);
  endfunction

  function automatic point_result_t transform_point(input logic [2:0] op,
                                                     input logic signed [15:0] x,
                                                     input logic signed [15:0] y);
    longint        px, py, dx, dy, rx, ry, cq, sq, tq, cx, cy;
    logic          ovf;
    point_result_t r;
    px = longint'(x);
    py = longint'(y);
    cq = longint'(cos_coef);
    sq = longint'(sin_coef);
    tq = longint'(tan_coef);
    cx = IMAGE_WIDTH / 2;
    cy = IMAGE_HEIGHT / 2;
    dx = px - cx;
    dy = py - cy;
    rx = px;
    ry = py;
    ovf = 1'b0;
    // longint division truncates toward zero
    case (op)
      OP_MIRROR_V: ry = IMAGE_HEIGHT - 1 - py;
      OP_MIRROR_H: rx = IMAGE_WIDTH - 1 - px;
      OP_ROT_ORIG: begin
        rx = (px * cq - py * sq) / 16384;
        ry = (px * sq + py * cq) / 16384;
      end
      OP_ROT_CTR: begin
        rx = cx + (dx * cq - dy * sq) / 16384;
        ry = cy + (dx * sq + dy * cq) / 16384;
      end
      OP_SHEAR_Y: ry = cy + (dy * 4096 + dx * tq) / 4096;
      OP_SHEAR_XY: begin
        rx = cx + (dx * 4096 + dy * tq) / 4096;
        ry = cy + (dy * 4096 + dx * tq) / 4096;
      end
      default: ;
    endcase
    r.x = clamp16(rx, ovf);
    r.y = clamp16(ry, ovf);
    r.ovf = ovf;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic signed [15:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 16'(int'($urandom_range(0, 511)) - 128);
    if (r < 8) return 16'($urandom);
    if (r == 8) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    // near either limit
    return $urandom_range(0, 1) ? 16'(32767 - int'($urandom_range(0, 200)))
                                : 16'(-32768 + int'($urandom_range(0, 200)));
  endfunction

  function automatic logic [2:0] pick_op();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
    return 3'($urandom_range(OP_MIRROR_V, OP_SHEAR_XY));
  endfunction

  // Scoreboard: output check first, then capture accepted inputs and cfg beats.
  always @(posedge clk) begin : scoreboard
    point_result_t want;
    if (rst) begin
      cos_coef <= COS_RESET;
      sin_coef <= SIN_RESET;
      tan_coef <= TAN_RESET;
    end else begin
      if (out_valid && out_ready) begin
        points_checked++;
        if (expected_points.size() == 0) begin
          errors++;
          if (errors <= 40)
            $display("%0t: unexpected beat x=%0d y=%0d ovf=%0b",
                     $realtime, x_out, y_out, overflow);
        end else begin
          want = expected_points.pop_front();
          if (x_out !== want.x || y_out !== want.y || overflow !== want.ovf) begin
            errors++;
            if (errors <= 40)
              $display("%0t: mismatch expected x=%0d y=%0d ovf=%0b, got x=%0d y=%0d ovf=%0b",
                       $realtime, want.x, want.y, want.ovf, x_out, y_out, overflow);
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_points.push_back(transform_point(opcode, x_in, y_in));
        points_sent++;
      end
      if (cfg_valid && cfg_ready) begin
        coef_writes++;
        case (cfg_index)
          REG_COS: cos_coef <= cfg_data;
          REG_SIN: sin_coef <= cfg_data;
          REG_TAN: tan_coef <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Output side: random stalls, plus a long hold when a test asks for one.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
    end
  end

  // Valid is left high after a beat so back-to-back beats need no toggle.
  task automatic send_point(input logic [2:0] op, input logic signed [15:0] x,
                            input logic signed [15:0] y);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    x_in     <= x;
    y_in     <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Waits on the clock first so the scoreboard has queued the last accepted beat.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_coef(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_coefs(input coef_set_t c, input bit poke_unused);
    wait_idle();
    write_coef(REG_COS, c.cos_q);
    write_coef(REG_SIN, c.sin_q);
    write_coef(REG_TAN, c.tan_q);
    // unmapped index must leave all coefficients alone
    if (poke_unused) write_coef(REG_NONE, 16'h5a5a);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_corners();
    for (int o = OP_MIRROR_V; o <= OP_UNUSED_7; o++) begin
      send_point(3'(o), 16'sh7fff, 16'sh8000);
      send_point(3'(o), 16'sh8000, 16'sh7fff);
    end
    send_point(OP_ROT_CTR, 16'(IMAGE_WIDTH / 2), 16'(IMAGE_HEIGHT / 2));
    send_point(OP_SHEAR_XY, 16'(IMAGE_WIDTH / 2), 16'(IMAGE_HEIGHT / 2));
    send_point(OP_MIRROR_V, 16'sd0, 16'sd0);
    send_point(OP_MIRROR_H, 16'(IMAGE_WIDTH - 1), 16'(IMAGE_HEIGHT - 1));
  endtask

  task automatic test_coef_settings();
    coef_set_t settings[6];
    settings[0] = '{16'sd0,      16'sd16384,  16'sd0};
    settings[1] = '{-16'sd16384, 16'sd0,      16'sh8000};
    settings[2] = '{16'sd11585,  16'sd11585,  16'sh7fff};
    settings[3] = '{16'sh7fff,   16'sh8000,   16'sd4096};
    settings[4] = '{-16'sd11585, 16'sd16384, -16'sd2365};
    settings[5] = '{COS_RESET,   SIN_RESET,   TAN_RESET};
    foreach (settings[i]) begin
      program_coefs(settings[i], i == 4);
      repeat (ITEMS_PER_SETTING) send_point(pick_op(), pick_coord(), pick_coord());
    end
  endtask

  task automatic test_output_backpressure();
    quiet = 1'b1;
    hold_req = HOLD_CYCLES;
    repeat (60) send_point(pick_op(), pick_coord(), pick_coord());
    quiet = 1'b0;
  endtask

  task automatic test_gapless_stream();
    quiet = 1'b1;
    repeat (150) send_point(pick_op(), pick_coord(), pick_coord());
    quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_corners();
    test_coef_settings();
    test_output_backpressure();
    test_gapless_stream();
    wait_idle();
    $display("checked %0d points against %0d sent, %0d cfg beats, 6 coefficient sets",
             points_checked, points_sent, coef_writes);
    $display("covered all opcodes, saturation corners, long output stall, gapless stream");
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d errors", errors);
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d points outstanding", expected_points.size());
    $display("tb failed");
    $finish;
  end

endmodule
